### hw/rtl/tbf_pkg.sv
package tbf_pkg;

    // Largest number of result beats that one input byte can cause.
    localparam int BurstMax = 5;
    localparam int CountW   = $clog2(BurstMax + 1);

    // Character codes used by the filter.
    localparam logic [7:0] ChEsc   = 8'd27;
    localparam logic [7:0] ChLpar  = 8'd40;
    localparam logic [7:0] ChRpar  = 8'd41;
    localparam logic [7:0] ChCr    = 8'd13;
    localparam logic [7:0] ChLf    = 8'd10;
    localparam logic [7:0] ChTab   = 8'd9;
    localparam logic [7:0] ChQuote = 8'd34;
    localparam logic [7:0] ChSlash = 8'd47;
    localparam logic [7:0] ChSpace = 8'd32;
    localparam logic [7:0] ChTilde = 8'd126;

    // Bytes dropped after the byte that follows an ESC, when that byte is not a parenthesis.
    localparam logic [2:0] SkipAfterMark = 3'd3;

    // Expanded output of one input byte, first character in entry 0.
    typedef struct packed {
        logic [CountW-1:0]          count;
        logic [BurstMax-1:0][7:0]   chars;
    } burst_t;

    // Serializer status seen by the top level.
    typedef struct packed {
        logic [CountW-1:0] left;
        logic              move;
    } ser_status_t;

endpackage

### hw/rtl/text_record_byte_filter.sv
// Channel   Direction  tdata (low bit up)    tlast        tuser
// s_axis    in         [7:0] data_byte       record_last  -
// m_axis    out        [7:0] out_byte        run_last     -
// cfg       in         cfg_wdata = quote_mode, written when cfg_we is high
//
// One input beat is taken per cycle when it yields at most one character and m_axis
// is not stalled. A byte that expands to several characters holds s_axis_tready low
// until its last character moves to the output register, which takes one per cycle while m_axis is ready.
// An input beat passes through the burst buffer and then the output register to m_axis.
// rst_n clears the filter state, quote_mode and both buffers at once.
// A stall on m_axis fills the burst buffer and then stops the input.
module text_record_byte_filter
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast
);
    import tbf_pkg::*;

    burst_t      burst;
    ser_status_t status;
    logic        take;

    assign take = s_axis_tvalid && s_axis_tready;

    tbf_decode u_decode
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .take        (take),
        .data_byte   (s_axis_tdata),
        .record_last (s_axis_tlast),
        .burst       (burst)
    );

    tbf_serial u_serial
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .burst     (burst),
        .load_ok   (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .status    (status)
    );

    // The burst buffer never holds more than one byte's expansion.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.left <= CountW'(BurstMax))
        else $error("burst count out of range");

    // A new byte is taken only when the buffer is about to drain.
    assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (status.left == '0 || (status.left == CountW'(1) && status.move)))
        else $error("input taken over an undrained burst");

    // The final character of a burst is marked as the end of its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (status.move && status.left == CountW'(1)) |=> (m_axis_tvalid && m_axis_tlast))
        else $error("run end not marked");

endmodule

### hw/rtl/tbf_decode.sv
module tbf_decode
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_wdata,
    input  logic            take,
    input  logic [7:0]      data_byte,
    input  logic            record_last,
    output tbf_pkg::burst_t burst
);
    import tbf_pkg::*;

    logic       quote_mode_reg;
    logic       cr_pending_reg;
    logic       cr_pending_next;
    logic       esc_pending_reg;
    logic       esc_pending_next;
    logic [2:0] skip_left_reg;
    logic [2:0] skip_left_next;

    // Expand one byte against the current marker and line-end state.
    always_comb
    begin
        logic [CountW-1:0] n;
        logic              do_plain;
        n                = '0;
        do_plain         = 1'b0;
        burst.chars      = '0;
        cr_pending_next  = cr_pending_reg;
        esc_pending_next = esc_pending_reg;
        skip_left_next   = skip_left_reg;

        if (esc_pending_reg)
        begin
            esc_pending_next = 1'b0;
            if (data_byte != ChLpar && data_byte != ChRpar)
            begin
                skip_left_next = SkipAfterMark;
            end
        end
        else if (skip_left_reg != 3'd0)
        begin
            skip_left_next = skip_left_reg - 3'd1;
        end
        else
        begin
            do_plain = 1'b1;
            if (cr_pending_reg)
            begin
                cr_pending_next = 1'b0;
                burst.chars[n] = ChCr;
                n = n + 1'b1;
                burst.chars[n] = ChLf;
                n = n + 1'b1;
                if (data_byte == ChLf)
                begin
                    do_plain = 1'b0;
                end
            end
        end

        // Ordinary handling of a byte outside any marker.
        if (do_plain)
        begin
            if (data_byte == ChEsc)
            begin
                esc_pending_next = 1'b1;
            end
            else if (data_byte == ChTab)
            begin
                burst.chars[n] = data_byte;
                n = n + 1'b1;
            end
            else if (data_byte == ChCr)
            begin
                cr_pending_next = 1'b1;
            end
            else if (data_byte == ChLf)
            begin
                burst.chars[n] = ChCr;
                n = n + 1'b1;
                burst.chars[n] = ChLf;
                n = n + 1'b1;
            end
            else if (data_byte >= ChSpace && data_byte <= ChTilde)
            begin
                if (quote_mode_reg && data_byte == ChQuote)
                begin
                    burst.chars[n] = ChSlash;
                    n = n + 1'b1;
                    burst.chars[n] = ChSlash;
                    n = n + 1'b1;
                end
                burst.chars[n] = data_byte;
                n = n + 1'b1;
            end
        end

        // End of record flushes a pending CR and cancels any marker.
        if (record_last)
        begin
            if (cr_pending_next)
            begin
                cr_pending_next = 1'b0;
                burst.chars[n] = ChCr;
                n = n + 1'b1;
                burst.chars[n] = ChLf;
                n = n + 1'b1;
            end
            esc_pending_next = 1'b0;
            skip_left_next   = 3'd0;
        end

        burst.count = n;
    end

    // Filter state advances on each accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_mode_reg  <= 1'b0;
            cr_pending_reg  <= 1'b0;
            esc_pending_reg <= 1'b0;
            skip_left_reg   <= 3'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                quote_mode_reg <= cfg_wdata;
            end
            if (take)
            begin
                cr_pending_reg  <= cr_pending_next;
                esc_pending_reg <= esc_pending_next;
                skip_left_reg   <= skip_left_next;
            end
        end
    end

endmodule

### hw/rtl/tbf_serial.sv
module tbf_serial
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  tbf_pkg::burst_t      burst,
    output logic                 load_ok,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 out_last,
    output tbf_pkg::ser_status_t status
);
    import tbf_pkg::*;

    logic [BurstMax-1:0][7:0] chars_reg;
    logic [CountW-1:0]        left_reg;
    logic                     valid_reg;
    logic [7:0]               byte_reg;
    logic                     last_reg;
    logic                     move;

    // A character moves to the output register when that register is free.
    assign move    = (left_reg != '0) && (!valid_reg || out_ready);
    assign load_ok = (left_reg == '0) || (left_reg == CountW'(1) && move);

    // Burst buffer: loaded whole, drained from entry 0 by shifting.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
        end
        else if (load)
        begin
            left_reg <= burst.count;
        end
        else if (move)
        begin
            left_reg <= left_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chars_reg <= burst.chars;
        end
        else if (move)
        begin
            for (int i = 0; i < BurstMax - 1; i++)
            begin
                chars_reg[i] <= chars_reg[i+1];
            end
            chars_reg[BurstMax-1] <= '0;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (move)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            byte_reg <= chars_reg[0];
            last_reg <= (left_reg == CountW'(1));
        end
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign out_last    = last_reg;
    assign status.left = left_reg;
    assign status.move = move;

endmodule

### verif/text_record_byte_filter_test.sv
`timescale 1ns / 100ps

module text_record_byte_filter_test;

    import tbf_pkg::*;

    localparam int IdleLimit    = 2000;
    localparam int SettleCycles = 8;
    localparam int HoldCycles   = 60;

    // Receiver stall patterns.
    typedef enum int {RxAlways, RxRandom, RxPattern, RxSparse} rx_mode_t;

    // One expected character on the output stream.
    typedef struct packed {
        logic [7:0] ch;
        logic       tail;
    } char_beat_t;

    // One directed row: quote mode, input byte, record end, and an optional fixed answer.
    typedef struct packed {
        logic       quote;
        logic [7:0] data;
        logic       last;
        logic       typed;
        burst_t     want;
    } plan_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] data_byte
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] out_byte
    logic       m_axis_tlast;

    // Filter state as the predictor sees it.
    logic       quote_on;
    logic       cr_wait;
    logic       esc_wait;
    logic [2:0] skip_cnt;

    char_beat_t pending_chars[$];
    plan_row_t  plan[$];

    int mismatches;
    int beats_in;
    int chars_out;
    int records_sent;
    int quote_writes;
    int burst_left;
    int idle_cycles;
    logic hold_req;

    text_record_byte_filter u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Append one character to an expanded byte.
    function automatic void add_char(inout burst_t r, input logic [7:0] c);
        r.chars[r.count] = c;
        r.count = r.count + 1'b1;
    endfunction

    // Normal handling of a byte outside any marker, also after a flushed pending CR.
    function automatic void plain_char(inout burst_t r, input logic [7:0] b);
        if (b == ChEsc)
            esc_wait = 1'b1;
        else if (b == ChTab)
            add_char(r, b);
        else if (b == ChCr)
            cr_wait = 1'b1;
        else if (b == ChLf)
        begin
            add_char(r, ChCr);
            add_char(r, ChLf);
        end
        else if (b >= ChSpace && b <= ChTilde)
        begin
            if (quote_on && b == ChQuote)
            begin
                add_char(r, ChSlash);
                add_char(r, ChSlash);
            end
            add_char(r, b);
        end
    endfunction

    // Characters that one accepted input byte expands to, updating the filter state.
    function automatic burst_t filter_byte(input logic [7:0] b, input logic last);
        burst_t r;
        r = '0;
        if (esc_wait)
        begin
            esc_wait = 1'b0;
            if (b != ChLpar && b != ChRpar)
                skip_cnt = SkipAfterMark;
        end
        else if (skip_cnt != 3'd0)
            skip_cnt = skip_cnt - 3'd1;
        else if (cr_wait)
        begin
            cr_wait = 1'b0;
            add_char(r, ChCr);
            add_char(r, ChLf);
            if (b != ChLf)
                plain_char(r, b);
        end
        else
            plain_char(r, b);

        // The end of a record flushes a pending CR and drops any marker in progress.
        if (last)
        begin
            if (cr_wait)
            begin
                cr_wait = 1'b0;
                add_char(r, ChCr);
                add_char(r, ChLf);
            end
            esc_wait = 1'b0;
            skip_cnt = 3'd0;
        end
        return r;
    endfunction

    function automatic void queue_burst(input burst_t w);
        for (int i = 0; i < int'(w.count); i++)
            pending_chars.push_back(char_beat_t'{w.chars[i], i == int'(w.count) - 1});
    endfunction

    function automatic burst_t mk(input int n, input logic [7:0] c0 = 8'h00,
                                  input logic [7:0] c1 = 8'h00, input logic [7:0] c2 = 8'h00,
                                  input logic [7:0] c3 = 8'h00, input logic [7:0] c4 = 8'h00);
        burst_t r;
        r = '0;
        r.count = n[CountW-1:0];
        r.chars[0] = c0;
        r.chars[1] = c1;
        r.chars[2] = c2;
        r.chars[3] = c3;
        r.chars[4] = c4;
        return r;
    endfunction

    function automatic plan_row_t row(input logic q, input logic [7:0] d, input logic l,
                                      input logic t = 1'b0, input burst_t w = '0);
        return plan_row_t'{q, d, l, t, w};
    endfunction

    // Offer one beat, in bursts with random gaps, and record what it should produce.
    task automatic send_byte(input logic [7:0] d, input logic l, input logic typed,
                             input burst_t want);
        burst_t got;
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = d;
        s_axis_tlast  = l;
        do
            @(posedge clk);
        while (!s_axis_tready);
        got = filter_byte(d, l);
        queue_burst(typed ? want : got);
        beats_in++;
        if (l)
            records_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    function automatic logic rand_last();
        return $urandom_range(0, 9) == 0;
    endfunction

    // Random text: mostly well-formed characters, line ends and markers, some noise.
    task automatic send_token();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            send_byte(8'($urandom_range(32, 126)), rand_last(), 1'b0, '0);
        else if (pick < 53)
            send_byte(ChQuote, rand_last(), 1'b0, '0);
        else if (pick < 59)
            send_byte(ChCr, rand_last(), 1'b0, '0);
        else if (pick < 65)
            send_byte(ChLf, rand_last(), 1'b0, '0);
        else if (pick < 70)
        begin
            send_byte(ChCr, 1'b0, 1'b0, '0);
            send_byte(ChLf, rand_last(), 1'b0, '0);
        end
        else if (pick < 74)
            send_byte(ChTab, rand_last(), 1'b0, '0);
        else if (pick < 79)
        begin
            send_byte(ChEsc, rand_last(), 1'b0, '0);
            send_byte($urandom_range(0, 1) ? ChLpar : ChRpar, rand_last(), 1'b0, '0);
        end
        else if (pick < 86)
        begin
            send_byte(ChEsc, rand_last(), 1'b0, '0);
            repeat (4) send_byte(8'($urandom_range(0, 255)), rand_last(), 1'b0, '0);
        end
        else
            send_byte(8'($urandom_range(0, 255)), rand_last(), 1'b0, '0);
    endtask

    // Let the block drain completely before touching its register.
    task automatic settle();
        s_axis_tvalid = 1'b0;
        burst_left = 0;
        while (pending_chars.size() != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic write_quote(input logic v);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we    = 1'b0;
        quote_on  = v;
        quote_writes++;
    endtask

    // Receiver: changes its stall pattern now and then, and honors one long hold-off.
    initial
    begin
        rx_mode_t mode;
        int mode_left;
        m_axis_tready = 1'b0;
        mode = RxAlways;
        mode_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready = 1'b0;
                repeat (HoldCycles) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                case (mode)
                    RxAlways:  m_axis_tready = 1'b1;
                    RxRandom:  m_axis_tready = ($urandom_range(0, 3) != 0);
                    RxPattern: m_axis_tready = (mode_left % 5 == 0);
                    default:   m_axis_tready = ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Compare each output beat with the oldest expected character.
    always @(posedge clk)
    begin
        char_beat_t exp_beat;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            chars_out++;
            if (pending_chars.size() == 0)
            begin
                mismatches++;
                $error("out_byte: no result expected, got %h", m_axis_tdata);
            end
            else
            begin
                exp_beat = pending_chars.pop_front();
                if (m_axis_tdata !== exp_beat.ch)
                begin
                    mismatches++;
                    $error("out_byte: expected %h, got %h", exp_beat.ch, m_axis_tdata);
                end
                if (m_axis_tlast !== exp_beat.tail)
                begin
                    mismatches++;
                    $error("run_last: expected %b, got %b", exp_beat.tail, m_axis_tlast);
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves a beat.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IdleLimit)
        begin
            $display("Timeout: no beat moved for %0d cycles, %0d results outstanding",
                     IdleLimit, pending_chars.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        hold_req      = 1'b0;
        quote_on      = 1'b0;
        cr_wait       = 1'b0;
        esc_wait      = 1'b0;
        skip_cnt      = 3'd0;
        mismatches    = 0;
        beats_in      = 0;
        chars_out     = 0;
        records_sent  = 0;
        quote_writes  = 0;
        burst_left    = 0;
        idle_cycles   = 0;

        // Directed rows with quote mode off.
        plan.push_back(row(1'b0, ChSpace, 1'b0, 1'b1, mk(1, ChSpace)));
        plan.push_back(row(1'b0, ChTilde, 1'b0, 1'b1, mk(1, ChTilde)));
        plan.push_back(row(1'b0, 8'h1F,   1'b0, 1'b1, mk(0)));
        plan.push_back(row(1'b0, 8'h7F,   1'b0, 1'b1, mk(0)));
        plan.push_back(row(1'b0, 8'hFF,   1'b0, 1'b1, mk(0)));
        plan.push_back(row(1'b0, ChTab,   1'b0, 1'b1, mk(1, ChTab)));
        plan.push_back(row(1'b0, ChQuote, 1'b0, 1'b1, mk(1, ChQuote)));
        plan.push_back(row(1'b0, ChLf,    1'b0, 1'b1, mk(2, ChCr, ChLf)));
        plan.push_back(row(1'b0, ChCr,    1'b0, 1'b1, mk(0)));
        plan.push_back(row(1'b0, ChLf,    1'b0, 1'b1, mk(2, ChCr, ChLf)));
        // A lone CR followed by a letter.
        plan.push_back(row(1'b0, ChCr,    1'b0));
        plan.push_back(row(1'b0, 8'h41,   1'b0));
        // Short marker with a parenthesis, then a full marker that swallows CR, LF and ESC.
        plan.push_back(row(1'b0, ChEsc,   1'b0));
        plan.push_back(row(1'b0, ChLpar,  1'b0));
        plan.push_back(row(1'b0, 8'h42,   1'b0));
        plan.push_back(row(1'b0, ChEsc,   1'b0));
        plan.push_back(row(1'b0, 8'h78,   1'b0));
        plan.push_back(row(1'b0, ChCr,    1'b0));
        plan.push_back(row(1'b0, ChLf,    1'b0));
        plan.push_back(row(1'b0, ChEsc,   1'b0));
        plan.push_back(row(1'b0, 8'h43,   1'b0));
        // Record ends: a pending CR is flushed, a marker is not carried over.
        plan.push_back(row(1'b0, ChCr,    1'b1, 1'b1, mk(2, ChCr, ChLf)));
        plan.push_back(row(1'b0, ChEsc,   1'b1));
        plan.push_back(row(1'b0, 8'h44,   1'b0));
        // Quote mode on, including the five-character worst case.
        plan.push_back(row(1'b1, ChQuote, 1'b0, 1'b1, mk(3, ChSlash, ChSlash, ChQuote)));
        plan.push_back(row(1'b1, ChEsc,   1'b0));
        plan.push_back(row(1'b1, ChRpar,  1'b0));
        plan.push_back(row(1'b1, ChCr,    1'b0));
        plan.push_back(row(1'b1, ChQuote, 1'b1));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        write_quote(1'b0);

        foreach (plan[i])
        begin
            if (plan[i].quote != quote_on)
            begin
                settle();
                write_quote(plan[i].quote);
            end
            send_byte(plan[i].data, plan[i].last, plan[i].typed, plan[i].want);
        end

        // Random phases over both quote settings; the second one holds the receiver off.
        for (int p = 0; p < 3; p++)
        begin
            int start_beats;
            settle();
            write_quote(p != 1);
            if (p == 1)
                hold_req = 1'b1;
            start_beats = beats_in;
            while (beats_in - start_beats < ((p == 2) ? 71 : 80))
                send_token();
        end

        settle();
        $display("Run sent %0d input beats in %0d records and checked %0d output beats,",
                 beats_in, records_sent, chars_out);
        $display("with %0d quote mode writes and one %0d-cycle receiver hold-off.",
                 quote_writes, HoldCycles);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
